### src/fct_pkg.sv
// Shared types, field layout and defaults for the frustum cull tester.
`timescale 1ns / 1ps

package fct_pkg;

    // Default configuration.
    localparam int NUM_PLANES_DEF = 6;
    localparam int FRAC_BITS_DEF  = 16;

    // Field widths.
    localparam int OP_W     = 2;
    localparam int PIDX_W   = 3;
    localparam int COORD_W  = 32;
    localparam int RADIUS_W = 31;

    // Slave tdata layout, lowest bit first.
    localparam int PIDX_LSB   = 0;
    localparam int AX_LSB     = PIDX_LSB + PIDX_W;
    localparam int AY_LSB     = AX_LSB + COORD_W;
    localparam int AZ_LSB     = AY_LSB + COORD_W;
    localparam int BX_LSB     = AZ_LSB + COORD_W;
    localparam int BY_LSB     = BX_LSB + COORD_W;
    localparam int BZ_LSB     = BY_LSB + COORD_W;
    localparam int RADIUS_LSB = BZ_LSB + COORD_W;
    localparam int OFFSET_LSB = RADIUS_LSB + RADIUS_W;
    localparam int S_FIELDS_W = OFFSET_LSB + COORD_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = 8;

    // One stored plane: normal and offset.
    localparam int PLANE_W = 4 * COORD_W;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD   = 2'd0,
        OP_POINT  = 2'd1,
        OP_SPHERE = 2'd2,
        OP_BOX    = 2'd3
    } op_t;

    // Operands of a test, held for the whole sweep over the planes.
    typedef struct packed {
        op_t                        op;
        logic signed [COORD_W-1:0]  ax;
        logic signed [COORD_W-1:0]  ay;
        logic signed [COORD_W-1:0]  az;
        logic signed [COORD_W-1:0]  bx;
        logic signed [COORD_W-1:0]  by;
        logic signed [COORD_W-1:0]  bz;
        logic [RADIUS_W-1:0]        radius;
    } fct_operands_t;

    // Control from the sequencer to the distance unit.
    typedef struct packed {
        logic clear;        // start of a test: drop the old verdict
        logic rd_valid;     // plane word from memory is valid this cycle
        logic entry_valid;  // that entry was loaded since reset
    } fct_dp_ctl_t;

    // Status from the distance unit to the sequencer.
    typedef struct packed {
        logic busy;         // a plane is still in the pipeline
        logic reject;       // some plane rejected the shape
    } fct_dp_status_t;

endpackage

### src/fct_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module fct_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 6,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### src/fct_plane_unit.sv
// Signed distance pipeline: vertex select, products, exact sum and reject flag.
`timescale 1ns / 1ps

module fct_plane_unit #(
    parameter int FRAC_BITS = fct_pkg::FRAC_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  fct_pkg::fct_dp_ctl_t         ctl,
    input  logic [fct_pkg::PLANE_W-1:0]  plane,
    input  fct_pkg::fct_operands_t       opnd,
    output fct_pkg::fct_dp_status_t      status
);

    import fct_pkg::*;

    // Room for three full products plus the scaled offset and radius terms.
    localparam int PROD_W = 2 * COORD_W;
    localparam int TERM_W = (COORD_W + 1 + FRAC_BITS > PROD_W) ?
                            (COORD_W + 1 + FRAC_BITS) : PROD_W;
    localparam int ACC_W  = TERM_W + 3;

    logic signed [COORD_W-1:0] nx, ny, nz, nd;
    logic signed [COORD_W-1:0] px, py, pz;
    logic signed [PROD_W-1:0]  prod_x_reg, prod_y_reg, prod_z_reg;
    logic signed [COORD_W-1:0] off_reg;
    logic [RADIUS_W-1:0]       bias_reg;
    logic                      mul_v_reg;
    logic                      reject_reg;
    logic signed [ACC_W-1:0]   acc;

    // An entry never loaded reads as the zero plane.
    always_comb begin
        if (ctl.entry_valid) begin
            nx = plane[0*COORD_W +: COORD_W];
            ny = plane[1*COORD_W +: COORD_W];
            nz = plane[2*COORD_W +: COORD_W];
            nd = plane[3*COORD_W +: COORD_W];
        end else begin
            nx = '0;
            ny = '0;
            nz = '0;
            nd = '0;
        end
    end

    // Box test uses the positive vertex; the other tests use the point as is.
    always_comb begin
        px = opnd.ax;
        py = opnd.ay;
        pz = opnd.az;
        if (opnd.op == OP_BOX) begin
            if (!nx[COORD_W-1]) px = opnd.bx;
            if (!ny[COORD_W-1]) py = opnd.by;
            if (!nz[COORD_W-1]) pz = opnd.bz;
        end
    end

    // Multiply stage: three independent 32x32 products.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_v_reg <= 1'b0;
        end else begin
            mul_v_reg <= ctl.rd_valid;
        end
        if (ctl.rd_valid) begin
            prod_x_reg <= nx * px;
            prod_y_reg <= ny * py;
            prod_z_reg <= nz * pz;
            off_reg    <= nd;
            bias_reg   <= (opnd.op == OP_SPHERE) ? opnd.radius : '0;
        end
    end

    // Exact sum at twice the fraction bits; only its sign matters.
    always_comb begin
        acc = ACC_W'(prod_x_reg) + ACC_W'(prod_y_reg) + ACC_W'(prod_z_reg)
            + (ACC_W'(off_reg) <<< FRAC_BITS)
            + (ACC_W'($signed({1'b0, bias_reg})) <<< FRAC_BITS);
    end

    // Sticky reject over the planes of one test.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reject_reg <= 1'b0;
        end else if (ctl.clear) begin
            reject_reg <= 1'b0;
        end else if (mul_v_reg && acc[ACC_W-1]) begin
            reject_reg <= 1'b1;
        end
    end

    assign status.busy   = mul_v_reg;
    assign status.reject = reject_reg;

endmodule

### src/frustum_cull_tester.sv
// Top level: plane memory, load path, test sequencer and result register.
//
//   Channel | Ports                    | Carries
//   --------+--------------------------+------------------------------------------
//   input   | s_tvalid s_tready s_tdata | plane_index, ax..bz, radius, offset
//           | s_tuser                   | operation
//   result  | m_tvalid m_tready m_tdata | inside_res
//           | m_tuser                   | was_test
//
// A load writes the plane memory in the accepting cycle. A test has the single read
// port of the plane memory visit one plane per cycle, then the read, multiply and
// sum stages drain, the verdict is stored and moved to the output register.
// aresetn clears all planes to zero through per-entry valid bits. A stalled
// result is held in the output register while the next transaction is
// accepted and processed.
`timescale 1ns / 1ps

module frustum_cull_tester #(
    parameter int NUM_PLANES = fct_pkg::NUM_PLANES_DEF,
    parameter int FRAC_BITS  = fct_pkg::FRAC_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // plane_index, ax, ay, az, bx, by, bz, radius, plane_offset, zero fill
    input  logic [fct_pkg::S_TDATA_W-1:0]  s_tdata,
    // operation
    input  logic [fct_pkg::OP_W-1:0]       s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // inside_res, zero fill
    output logic [fct_pkg::M_TDATA_W-1:0]  m_tdata,
    // was_test
    output logic                           m_tuser
);

    import fct_pkg::*;

    localparam int PA_W = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    state_t              state_reg, state_next;
    logic [PA_W-1:0]     cnt_reg, cnt_next;
    logic                rd_v_reg, rd_v_next;
    logic                ent_v_reg, ent_v_next;
    logic                valid_reg [NUM_PLANES];
    logic                res_inside_reg, res_inside_next;
    logic                res_test_reg, res_test_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic                inside_reg, inside_next;
    logic                was_test_reg, was_test_next;
    fct_operands_t       opnd_reg;

    logic                s_fire;
    op_t                 s_op;
    logic [PIDX_W-1:0]   s_pidx;
    logic [PA_W+PIDX_W-1:0] pidx_ext;
    logic [PA_W-1:0]     waddr;
    logic                we;
    logic [PLANE_W-1:0]  wdata;
    logic [PLANE_W-1:0]  rdata;
    fct_dp_ctl_t         dp_ctl;
    fct_dp_status_t      dp_status;

    // Input decode and plane write.
    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign s_op     = op_t'(s_tuser);
    assign s_pidx   = s_tdata[PIDX_LSB +: PIDX_W];
    assign pidx_ext = {{PA_W{1'b0}}, s_pidx};
    assign waddr    = pidx_ext[PA_W-1:0];
    assign we       = s_fire && (s_op == OP_LOAD)
                      && ({{PA_W{1'b0}}, s_pidx} < (PA_W + PIDX_W)'(NUM_PLANES));
    assign wdata    = {s_tdata[OFFSET_LSB +: COORD_W], s_tdata[AZ_LSB +: COORD_W],
                       s_tdata[AY_LSB +: COORD_W], s_tdata[AX_LSB +: COORD_W]};

    fct_ram #(
        .WIDTH (PLANE_W),
        .DEPTH (NUM_PLANES),
        .AW    (PA_W)
    ) u_plane_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (state_reg == ST_RUN),
        .raddr (cnt_reg),
        .rdata (rdata)
    );

    assign dp_ctl.clear       = s_fire && (s_op != OP_LOAD);
    assign dp_ctl.rd_valid    = rd_v_reg;
    assign dp_ctl.entry_valid = ent_v_reg;

    fct_plane_unit #(
        .FRAC_BITS (FRAC_BITS)
    ) u_plane_unit (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (dp_ctl),
        .plane   (rdata),
        .opnd    (opnd_reg),
        .status  (dp_status)
    );

    // Sequencer and result register next values.
    always_comb begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        rd_v_next       = 1'b0;
        ent_v_next      = 1'b0;
        res_inside_next = res_inside_reg;
        res_test_next   = res_test_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        inside_next     = inside_reg;
        was_test_next   = was_test_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (s_op == OP_LOAD) begin
                        res_inside_next = 1'b0;
                        res_test_next   = 1'b0;
                        state_next      = ST_DONE;
                    end else begin
                        cnt_next   = '0;
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                rd_v_next  = 1'b1;
                ent_v_next = valid_reg[cnt_reg];
                if (cnt_reg == PA_W'(NUM_PLANES - 1)) begin
                    state_next = ST_DRAIN;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DRAIN: begin
                if (!rd_v_reg && !dp_status.busy) begin
                    res_inside_next = !dp_status.reject;
                    res_test_next   = 1'b1;
                    state_next      = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    inside_next   = res_inside_reg;
                    was_test_next = res_test_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State, counters, valid bits and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            rd_v_reg     <= 1'b0;
            ent_v_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < NUM_PLANES; i++) begin
                valid_reg[i] <= 1'b0;
            end
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            rd_v_reg     <= rd_v_next;
            ent_v_reg    <= ent_v_next;
            m_tvalid_reg <= m_tvalid_next;
            if (we) begin
                valid_reg[waddr] <= 1'b1;
            end
        end
        res_inside_reg <= res_inside_next;
        res_test_reg   <= res_test_next;
        inside_reg     <= inside_next;
        was_test_reg   <= was_test_next;
    end

    // Operand capture at the start of a test.
    always_ff @(posedge aclk) begin
        if (dp_ctl.clear) begin
            opnd_reg.op     <= s_op;
            opnd_reg.ax     <= s_tdata[AX_LSB +: COORD_W];
            opnd_reg.ay     <= s_tdata[AY_LSB +: COORD_W];
            opnd_reg.az     <= s_tdata[AZ_LSB +: COORD_W];
            opnd_reg.bx     <= s_tdata[BX_LSB +: COORD_W];
            opnd_reg.by     <= s_tdata[BY_LSB +: COORD_W];
            opnd_reg.bz     <= s_tdata[BZ_LSB +: COORD_W];
            opnd_reg.radius <= s_tdata[RADIUS_LSB +: RADIUS_W];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W - 1){1'b0}}, inside_reg};
    assign m_tuser  = was_test_reg;

endmodule

### tb/tb_frustum_cull_tester.sv
// Self-checking testbench for the frustum cull tester: random load and test traffic.
`timescale 1ns / 1ps

module tb_frustum_cull_tester;
    import fct_pkg::*;

    localparam int N_PL = NUM_PLANES_DEF;
    localparam int FRAC = FRAC_BITS_DEF;
    localparam logic signed [COORD_W-1:0] Q_ONE = 32'sd1 <<< FRAC;
    localparam logic signed [COORD_W-1:0] Q_MIN = 32'sh8000_0000;
    localparam logic signed [COORD_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam int RAND_ITEMS = 1250;

    // One input transaction, field by field.
    typedef struct packed {
        op_t                        op;
        logic [PIDX_W-1:0]          pidx;
        logic signed [COORD_W-1:0]  ax;
        logic signed [COORD_W-1:0]  ay;
        logic signed [COORD_W-1:0]  az;
        logic signed [COORD_W-1:0]  bx;
        logic signed [COORD_W-1:0]  by;
        logic signed [COORD_W-1:0]  bz;
        logic [RADIUS_W-1:0]        radius;
        logic signed [COORD_W-1:0]  offs;
    } cull_req_t;

    // One result transaction.
    typedef struct packed {
        logic inside_res;
        logic was_test;
    } verdict_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic [OP_W-1:0]       s_tuser = OP_LOAD;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tuser;

    cull_req_t  pending_reqs[$];
    verdict_t   expected_verdicts[$];
    cull_req_t  in_flight;
    logic [S_TDATA_W-1:0] req_word;
    logic       launch;
    int         src_gap = 0;
    bit         src_burst = 1'b0;
    int         sink_wait = 0;
    bit         sink_burst = 1'b0;
    int         accepted_cnt = 0;
    int         hold_left = 0;
    int         holds_taken = 0;
    int         errors = 0;
    verdict_t   want;

    // Predictor copy of the plane memory.
    logic signed [COORD_W-1:0] pl_nx [N_PL];
    logic signed [COORD_W-1:0] pl_ny [N_PL];
    logic signed [COORD_W-1:0] pl_nz [N_PL];
    logic signed [COORD_W-1:0] pl_d  [N_PL];

    frustum_cull_tester u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    function automatic logic signed [71:0] widen(logic signed [COORD_W-1:0] v);
        widen = 72'(v);
    endfunction

    // Exact signed distance of a point to plane i, plus a bias, compared with zero.
    function automatic logic plane_behind(int i, logic signed [COORD_W-1:0] px,
                                          logic signed [COORD_W-1:0] py,
                                          logic signed [COORD_W-1:0] pz,
                                          logic [RADIUS_W-1:0] bias);
        logic signed [71:0] wbias;
        logic signed [71:0] sdist;
        wbias = {41'd0, bias};
        sdist = widen(pl_nx[i]) * widen(px) + widen(pl_ny[i]) * widen(py)
              + widen(pl_nz[i]) * widen(pz) + (widen(pl_d[i]) <<< FRAC)
              + (wbias <<< FRAC);
        return sdist < 0;
    endfunction

    // Applies one accepted transaction to the plane copy and returns its verdict.
    function automatic verdict_t predict_verdict(cull_req_t rq);
        verdict_t vd;
        logic signed [COORD_W-1:0] vx, vy, vz;
        vd.was_test = (rq.op != OP_LOAD);
        vd.inside_res = 1'b0;
        if (rq.op == OP_LOAD) begin
            // Indexes past the last plane are acknowledged but write nothing.
            if (rq.pidx < N_PL) begin
                pl_nx[rq.pidx] = rq.ax;
                pl_ny[rq.pidx] = rq.ay;
                pl_nz[rq.pidx] = rq.az;
                pl_d[rq.pidx]  = rq.offs;
            end
        end else begin
            vd.inside_res = 1'b1;
            for (int i = 0; i < N_PL; i++) begin
                case (rq.op)
                    OP_POINT: begin
                        if (plane_behind(i, rq.ax, rq.ay, rq.az, '0)) vd.inside_res = 1'b0;
                    end
                    OP_SPHERE: begin
                        if (plane_behind(i, rq.ax, rq.ay, rq.az, rq.radius)) begin
                            vd.inside_res = 1'b0;
                        end
                    end
                    default: begin
                        // Positive vertex: box maximum where the normal is not negative.
                        vx = (pl_nx[i] >= 0) ? rq.bx : rq.ax;
                        vy = (pl_ny[i] >= 0) ? rq.by : rq.ay;
                        vz = (pl_nz[i] >= 0) ? rq.bz : rq.az;
                        if (plane_behind(i, vx, vy, vz, '0)) vd.inside_res = 1'b0;
                    end
                endcase
            end
        end
        return vd;
    endfunction

    // The radius argument is taken at coordinate width and cut to its field.
    task automatic push_req(op_t op, int idx, logic signed [COORD_W-1:0] ax, ay, az,
                            bx, by, bz, logic [COORD_W-1:0] r,
                            logic signed [COORD_W-1:0] d);
        cull_req_t rq;
        rq.op = op;
        rq.pidx = idx[PIDX_W-1:0];
        rq.ax = ax;
        rq.ay = ay;
        rq.az = az;
        rq.bx = bx;
        rq.by = by;
        rq.bz = bz;
        rq.radius = r[RADIUS_W-1:0];
        rq.offs = d;
        pending_reqs.push_back(rq);
    endtask

    // Mostly coordinates near the frustum, sometimes extremes or any pattern.
    function automatic logic signed [COORD_W-1:0] rand_coord();
        logic signed [COORD_W-1:0] v;
        case ($urandom_range(0, 9))
            0: v = $urandom;
            1: begin
                case ($urandom_range(0, 3))
                    0: v = Q_MIN;
                    1: v = Q_MAX;
                    2: v = '0;
                    default: v = -32'sd1;
                endcase
            end
            default: v = $urandom_range(0, 32 * Q_ONE) - 16 * Q_ONE;
        endcase
        return v;
    endfunction

    // Box maximum from its minimum; now and then unrelated, so it may lie below.
    function automatic logic signed [COORD_W-1:0] rand_span(logic signed [COORD_W-1:0] lo);
        if ($urandom_range(0, 7) == 0) return rand_coord();
        return lo + $urandom_range(0, 8 * Q_ONE);
    endfunction

    // Radius pattern at coordinate width; the request keeps its low bits.
    function automatic logic [COORD_W-1:0] rand_radius();
        if ($urandom_range(0, 7) == 0) return $urandom;
        return $urandom_range(0, 8 * Q_ONE);
    endfunction

    function automatic logic signed [COORD_W-1:0] jitter();
        return $urandom_range(0, Q_ONE / 2) - Q_ONE / 4;
    endfunction

    // Driver: offers queued transactions with random gaps between them.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            src_gap = 0;
        end else begin
            launch = s_tvalid;
            if (s_tvalid && s_tready) begin
                expected_verdicts.push_back(predict_verdict(in_flight));
                accepted_cnt <= accepted_cnt + 1;
                launch = 1'b0;
                if ($urandom_range(0, 39) == 0) src_burst = !src_burst;
                src_gap = src_burst ? 0 : $urandom_range(0, 6);
            end
            if (!launch) begin
                if (src_gap > 0) begin
                    src_gap--;
                end else if (pending_reqs.size() != 0) begin
                    in_flight = pending_reqs.pop_front();
                    req_word = '0;
                    req_word[PIDX_LSB +: PIDX_W]     = in_flight.pidx;
                    req_word[AX_LSB +: COORD_W]      = in_flight.ax;
                    req_word[AY_LSB +: COORD_W]      = in_flight.ay;
                    req_word[AZ_LSB +: COORD_W]      = in_flight.az;
                    req_word[BX_LSB +: COORD_W]      = in_flight.bx;
                    req_word[BY_LSB +: COORD_W]      = in_flight.by;
                    req_word[BZ_LSB +: COORD_W]      = in_flight.bz;
                    req_word[RADIUS_LSB +: RADIUS_W] = in_flight.radius;
                    req_word[OFFSET_LSB +: COORD_W]  = in_flight.offs;
                    s_tdata <= req_word;
                    s_tuser <= in_flight.op;
                    launch = 1'b1;
                end
            end
            s_tvalid <= launch;
        end
    end

    // Long receiver hold-offs so the block backs up and stalls its input.
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (holds_taken < 2 && accepted_cnt >= 200 + 700 * holds_taken) begin
            hold_left <= 300;
            holds_taken <= holds_taken + 1;
        end
    end

    // Monitor: checks each result transaction and stalls at random.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            sink_wait = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_verdicts.size() == 0) begin
                    $error("unexpected result: inside_res %0b was_test %0b",
                           m_tdata[0], m_tuser);
                    errors++;
                end else begin
                    want = expected_verdicts.pop_front();
                    if (m_tdata[0] !== want.inside_res) begin
                        $error("inside_res mismatch: expected %0b, actual %0b",
                               want.inside_res, m_tdata[0]);
                        errors++;
                    end
                    if (m_tuser !== want.was_test) begin
                        $error("was_test mismatch: expected %0b, actual %0b",
                               want.was_test, m_tuser);
                        errors++;
                    end
                end
                if ($urandom_range(0, 39) == 0) sink_burst = !sink_burst;
                sink_wait = sink_burst ? 0 : $urandom_range(0, 6);
            end else if (sink_wait > 0) begin
                sink_wait--;
            end
            m_tready <= (sink_wait == 0) && (hold_left == 0);
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        int rand_cnt;
        int total;
        logic signed [COORD_W-1:0] lx, ly, lz;
        logic signed [COORD_W-1:0] nrm [3];
        op_t op;

        // Planes never loaded reject nothing.
        push_req(OP_POINT, 0, Q_MAX, Q_MAX, Q_MAX, 0, 0, 0, 0, 0);
        push_req(OP_SPHERE, 7, Q_MIN, Q_MIN, Q_MIN, 0, 0, 0, 0, Q_MIN);
        push_req(OP_BOX, 0, Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 0);
        // Loads past the last plane write nothing.
        push_req(OP_LOAD, 6, Q_ONE, 0, 0, 0, 0, 0, 0, Q_MIN);
        push_req(OP_LOAD, 7, 0, Q_ONE, 0, 0, 0, 0, 0, Q_MIN);
        push_req(OP_POINT, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        // Plane x >= 0: a point just behind and one on the plane.
        push_req(OP_LOAD, 0, Q_ONE, 0, 0, 0, 0, 0, 0, 0);
        push_req(OP_POINT, 0, -32'sd1, 0, 0, 0, 0, 0, 0, 0);
        push_req(OP_POINT, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        // Sphere touching the plane from behind, then one step short.
        push_req(OP_SPHERE, 0, -Q_ONE, 0, 0, 0, 0, 0, Q_ONE, 0);
        push_req(OP_SPHERE, 0, -Q_ONE, 0, 0, 0, 0, 0, Q_ONE - 1, 0);
        // Plane y <= 5 with a negative normal picks the box minimum on y.
        push_req(OP_LOAD, 1, 0, -Q_ONE, 0, 0, 0, 0, 0, 5 * Q_ONE);
        push_req(OP_BOX, 0, -2 * Q_ONE, -2 * Q_ONE, -2 * Q_ONE,
                 2 * Q_ONE, 2 * Q_ONE, 2 * Q_ONE, 0, 0);
        push_req(OP_BOX, 0, -3 * Q_ONE, 6 * Q_ONE, 0, -Q_ONE, 7 * Q_ONE, 0, 0, 0);
        // Box with its minimum above its maximum.
        push_req(OP_BOX, 0, Q_ONE, Q_ONE, Q_ONE, -Q_ONE, -Q_ONE, -Q_ONE, 0, 0);
        push_req(OP_BOX, 0, -Q_ONE, 6 * Q_ONE, Q_ONE, Q_ONE, 4 * Q_ONE, -Q_ONE, 0, 0);
        // Extreme normals and offsets.
        push_req(OP_LOAD, 2, Q_MIN, Q_MIN, Q_MIN, 0, 0, 0, 0, Q_MAX);
        push_req(OP_POINT, 0, Q_MIN, Q_MIN, Q_MIN, 0, 0, 0, 0, 0);
        push_req(OP_LOAD, 3, Q_MAX, Q_MAX, Q_MAX, 0, 0, 0, 0, Q_MIN);
        push_req(OP_SPHERE, 0, Q_MAX, Q_MAX, Q_MAX, 0, 0, 0, Q_MAX, 0);
        push_req(OP_LOAD, 4, 0, 0, -Q_ONE, 0, 0, 0, 0, Q_ONE);
        push_req(OP_LOAD, 5, 0, 0, Q_ONE, 0, 0, 0, 0, Q_ONE);
        push_req(OP_BOX, 0, Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX, 0, 0);
        push_req(OP_SPHERE, 0, Q_MAX, Q_MIN, 0, 0, 0, 0, Q_MAX, 0);

        // Random part: load a jittered box-shaped frustum, then probe it.
        rand_cnt = 0;
        while (rand_cnt < RAND_ITEMS) begin
            for (int p = 0; p < N_PL; p++) begin
                for (int k = 0; k < 3; k++) begin
                    nrm[k] = jitter();
                    if (k == p / 2) nrm[k] = nrm[k] + ((p % 2) ? -Q_ONE : Q_ONE);
                end
                push_req(OP_LOAD, p, nrm[0], nrm[1], nrm[2], $urandom, $urandom,
                         $urandom, $urandom, $urandom_range(Q_ONE, 12 * Q_ONE));
            end
            rand_cnt += N_PL;
            repeat ($urandom_range(15, 40)) begin
                if ($urandom_range(0, 9) == 0) begin
                    // Stray load, possibly to a missing plane.
                    push_req(OP_LOAD, $urandom_range(0, 7), rand_coord(), rand_coord(),
                             rand_coord(), $urandom, $urandom, $urandom, $urandom,
                             ($urandom_range(0, 3) == 0) ? $urandom : rand_coord());
                end else begin
                    op = op_t'($urandom_range(1, 3));
                    lx = rand_coord();
                    ly = rand_coord();
                    lz = rand_coord();
                    if (op == OP_BOX) begin
                        push_req(op, $urandom_range(0, 7), lx, ly, lz, rand_span(lx),
                                 rand_span(ly), rand_span(lz), $urandom, $urandom);
                    end else begin
                        push_req(op, $urandom_range(0, 7), lx, ly, lz, $urandom,
                                 $urandom, $urandom, rand_radius(), $urandom);
                    end
                end
                rand_cnt++;
            end
        end
        total = pending_reqs.size();

        foreach (pl_nx[i]) begin
            pl_nx[i] = '0;
            pl_ny[i] = '0;
            pl_nz[i] = '0;
            pl_d[i]  = '0;
        end
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Wait until every transaction is accepted and answered, then drain.
        do @(negedge aclk); while (accepted_cnt < total || expected_verdicts.size() != 0);
        repeat (20) @(posedge aclk);
        @(negedge aclk);
        if (errors == 0 && expected_verdicts.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #3_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

### files.f
src/fct_pkg.sv
src/fct_ram.sv
src/fct_plane_unit.sv
src/frustum_cull_tester.sv
tb/tb_frustum_cull_tester.sv
